// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Uses the clk and rst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/gcdb_pkg.sv =====
// Package for the great-circle distance/bearing block: constants, types, helpers.
// No dependencies.
package gcdb_pkg;

    typedef enum logic [1:0] {
        REG_HOME_LAT = 2'd0,
        REG_HOME_LON = 2'd1,
        REG_HOME_SET = 2'd2
    } cfg_reg_t;

    localparam int CW = 34;           // rotation CORDIC datapath width
    localparam int VW = 36;           // vectoring CORDIC datapath width
    localparam int QW = 34;           // Q30 product width
    localparam int SQRT_STAGES = 31;  // one root bit per stage
    localparam int SQW = 62;          // sqrt datapath width

    localparam logic [63:0] DEG_TO_RADQ = 64'd4024455254;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic signed [VW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [29:0] RADIUS_CM = 30'd637100000;
    localparam logic [30:0] RAD_TO_CDEG = 31'd1501974481;
    localparam logic signed [30:0] LAT_LIMIT = 31'sd900000000;
    localparam logic signed [33:0] LON_TURN = 34'sd3600000000;
    localparam logic signed [33:0] LON_HALF = 34'sd1800000000;
    localparam logic [30:0] DIST_MAX = 31'd2001508680;
    localparam logic signed [16:0] CDEG_TURN = 17'sd36000;

    localparam logic signed [35:0] ATAN_LOW [10] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
        36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
        36'sd4194283, 36'sd2097149
    };

    function automatic logic signed [35:0] atan_q30(input int i);
        logic signed [35:0] v;
        if (i < 10)
        begin
            v = ATAN_LOW[i];
        end
        else if (i <= 30)
        begin
            v = 36'sd1 <<< (30 - i);
        end
        else
        begin
            v = '0;
        end
        return v;
    endfunction

    function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
        logic signed [30:0] r;
        if (v > LAT_LIMIT)
        begin
            r = LAT_LIMIT;
        end
        else if (v < -LAT_LIMIT)
        begin
            r = -LAT_LIMIT;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // degree units to Q30 radians; half selects the half-angle scale
    function automatic logic signed [31:0] to_q30(input logic signed [31:0] u,
                                                  input logic half);
        logic [31:0] m;
        logic [63:0] p;
        logic [63:0] r;
        m = u[31] ? 32'(-u) : 32'(u);
        p = 64'(m) * DEG_TO_RADQ;
        r = half ? ((p + 64'd2147483648) >> 32) : ((p + 64'd1073741824) >> 31);
        return u[31] ? -$signed(r[31:0]) : $signed(r[31:0]);
    endfunction

endpackage

// ===== hdl/gcdb_if.sv =====
// Channel interfaces: position items in, distance/bearing items out.
// Independent of the package.
interface gcdb_pos_if;
    logic               valid;
    logic               ready;
    logic signed [30:0] cur_lat;
    logic signed [31:0] cur_lon;

    modport source (output valid, cur_lat, cur_lon, input ready);
    modport sink (input valid, cur_lat, cur_lon, output ready);
endinterface

interface gcdb_res_if;
    logic        valid;
    logic        ready;
    logic        home_known;
    logic [30:0] distance_cm;
    logic [15:0] bearing_cdeg;

    modport source (output valid, home_known, distance_cm, bearing_cdeg, input ready);
    modport sink (input valid, home_known, distance_cm, bearing_cdeg, output ready);
endinterface

// ===== hdl/great_circle_distance_bearing.sv =====
// Top level: haversine distance and initial bearing to a configured home point.
// Depends on gcdb_pkg, gcdb_if, gcdb_dly, gcdb_rot, gcdb_sqrt, gcdb_vec, assert_macros.svh.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+---------------------------------------
//  pos      | in  | valid/ready  | cur_lat, cur_lon (1e-7 deg)
//  res      | out | valid/ready  | home_known, distance_cm, bearing_cdeg
//  cfg      | in  | cfg_we       | cfg_idx, cfg_data (home_lat/lon/set)
//
// One item per cycle sustained while res takes results; the path runs through
// two CORDIC pipelines of CORDIC_STAGES plus the 31-stage square root.
// The whole pipe advances together; it stalls only when the last stage
// holds an item that res does not take, so an item is accepted while
// earlier ones are in flight. rst_n clears the valid bits and the home
// registers; the datapath carries no reset.
`include "assert_macros.svh"

module great_circle_distance_bearing #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    gcdb_pos_if.sink          pos,
    gcdb_res_if.source        res,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_idx,
    input  logic [31:0]       cfg_data
);
    localparam int R   = CORDIC_STAGES;
    localparam int QW  = gcdb_pkg::QW;
    localparam int VW  = gcdb_pkg::VW;
    localparam int NS  = gcdb_pkg::SQRT_STAGES;
    localparam int L   = 39 + 2 * R;     // total register stages

    // ---------------- configuration ----------------
    logic signed [30:0] home_lat_reg;
    logic signed [31:0] home_lon_reg;
    logic               home_set_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_lat_reg <= '0;
            home_lon_reg <= '0;
            home_set_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (gcdb_pkg::cfg_reg_t'(cfg_idx))
                gcdb_pkg::REG_HOME_LAT: home_lat_reg <= cfg_data[30:0];
                gcdb_pkg::REG_HOME_LON: home_lon_reg <= cfg_data;
                gcdb_pkg::REG_HOME_SET: home_set_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic en;
    logic vld_reg [L];
    logic kn_reg  [L];

    assign en        = !vld_reg[L-1] || res.ready;
    assign pos.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L; i++)
            begin
                vld_reg[i] <= 1'b0;
                kn_reg[i]  <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= pos.valid;
            kn_reg[0]  <= home_set_reg;
            for (int i = 1; i < L; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
                kn_reg[i]  <= kn_reg[i-1];
            end
        end
    end

    // ---------------- stage A: clamp and differences ----------------
    logic signed [30:0] cl_next, hl_next;
    logic signed [31:0] dl_next;
    logic signed [33:0] dn_w;
    logic signed [30:0] cl_reg, hl_reg;
    logic signed [31:0] dl_reg, dn_reg;

    always_comb
    begin
        cl_next = gcdb_pkg::clamp_lat(pos.cur_lat);
        hl_next = gcdb_pkg::clamp_lat(home_lat_reg);
        dl_next = 32'(cl_next) - 32'(hl_next);
        dn_w    = 34'(home_lon_reg) - 34'(pos.cur_lon);
        // wrap longitude difference into [-180, 180)
        if (dn_w >= gcdb_pkg::LON_HALF)  dn_w = dn_w - gcdb_pkg::LON_TURN;
        if (dn_w >= gcdb_pkg::LON_HALF)  dn_w = dn_w - gcdb_pkg::LON_TURN;
        if (dn_w < -gcdb_pkg::LON_HALF)  dn_w = dn_w + gcdb_pkg::LON_TURN;
        if (dn_w < -gcdb_pkg::LON_HALF)  dn_w = dn_w + gcdb_pkg::LON_TURN;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_reg <= cl_next;
            hl_reg <= hl_next;
            dl_reg <= dl_next;
            dn_reg <= dn_w[31:0];
        end
    end

    // ---------------- stage B: degrees to Q30 radians ----------------
    logic signed [31:0] zcl_reg, zhl_reg, zdl_reg, zdn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zcl_reg <= gcdb_pkg::to_q30(32'(cl_reg), 1'b0);
            zhl_reg <= gcdb_pkg::to_q30(32'(hl_reg), 1'b0);
            zdl_reg <= gcdb_pkg::to_q30(dl_reg, 1'b1);
            zdn_reg <= gcdb_pkg::to_q30(dn_reg, 1'b1);
        end
    end

    // ---------------- sin/cos pipelines ----------------
    logic signed [31:0] cc, sc, ch, sh, cd, sd, hc, hs;

    gcdb_rot #(.STAGES(R)) u_rot_cur  (.clk, .en, .z_in(zcl_reg), .c_out(cc), .s_out(sc));
    gcdb_rot #(.STAGES(R)) u_rot_home (.clk, .en, .z_in(zhl_reg), .c_out(ch), .s_out(sh));
    gcdb_rot #(.STAGES(R)) u_rot_dlat (.clk, .en, .z_in(zdl_reg), .c_out(cd), .s_out(sd));
    gcdb_rot #(.STAGES(R)) u_rot_dlon (.clk, .en, .z_in(zdn_reg), .c_out(hc), .s_out(hs));

    // ---------------- stage C: first products ----------------
    logic signed [63:0] p_sdn2, p_sdsd, p_ccch, p_hshc, p_hchc, p_scch, p_ccsh;
    logic signed [QW-1:0] sdn2_reg, sdsd_reg, ccch_reg, hshc_reg, hchc_reg;
    logic signed [QW-1:0] scch_reg, ccsh_reg;
    logic signed [31:0]   ch_c_reg;

    assign p_sdn2 = hs * hs;
    assign p_sdsd = sd * sd;
    assign p_ccch = cc * ch;
    assign p_hshc = hs * hc;
    assign p_hchc = hc * hc;
    assign p_scch = sc * ch;
    assign p_ccsh = cc * sh;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sdn2_reg <= QW'(p_sdn2 >>> 30);
            sdsd_reg <= QW'(p_sdsd >>> 30);
            ccch_reg <= QW'(p_ccch >>> 30);
            hshc_reg <= QW'(p_hshc >>> 30);
            hchc_reg <= QW'(p_hchc >>> 30);
            scch_reg <= QW'(p_scch >>> 30);
            ccsh_reg <= QW'(p_ccsh >>> 30);
            ch_c_reg <= ch;
        end
    end

    // ---------------- stage D: second products ----------------
    logic signed [71:0] p_hav, p_by, p_t;
    logic signed [34:0] sin_dn, cos_dn;
    logic signed [VW-1:0] a_raw_reg, by_d_reg, t_reg;
    logic signed [QW-1:0] ccsh_d_reg;

    assign sin_dn = 35'(hshc_reg) <<< 1;
    assign cos_dn = 35'(hchc_reg) - 35'(sdn2_reg);
    assign p_hav  = ccch_reg * sdn2_reg;
    assign p_by   = sin_dn * ch_c_reg;
    assign p_t    = scch_reg * cos_dn;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_raw_reg  <= VW'(sdsd_reg) + VW'(p_hav >>> 30);
            by_d_reg   <= VW'(p_by >>> 30);
            t_reg      <= VW'(p_t >>> 30);
            ccsh_d_reg <= ccsh_reg;
        end
    end

    // ---------------- stage E: clamp a, bearing operands ----------------
    logic [30:0]          a_c;
    logic [60:0]          rad_a_reg, rad_b_reg;
    logic signed [VW-1:0] by_e_reg, bx_e_reg;

    always_comb
    begin
        if (a_raw_reg[VW-1])
        begin
            a_c = '0;
        end
        else if (a_raw_reg > VW'(gcdb_pkg::Q30_ONE))
        begin
            a_c = gcdb_pkg::Q30_ONE;
        end
        else
        begin
            a_c = a_raw_reg[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_a_reg <= {a_c, 30'd0};
            rad_b_reg <= {gcdb_pkg::Q30_ONE - a_c, 30'd0};
            by_e_reg  <= by_d_reg;
            bx_e_reg  <= VW'(ccsh_d_reg) - t_reg;
        end
    end

    // ---------------- square roots, bearing operands ride alongside ----------------
    logic [30:0]          sa, sb;
    logic [2*VW-1:0]      bop_q;
    logic signed [VW-1:0] theta_z, bear_z;

    gcdb_sqrt u_sqrt_a (.clk, .en, .n_in(rad_a_reg), .root(sa));
    gcdb_sqrt u_sqrt_b (.clk, .en, .n_in(rad_b_reg), .root(sb));

    gcdb_dly #(.W(2 * VW), .N(NS)) u_bop_dly (
        .clk, .en,
        .d({by_e_reg, bx_e_reg}),
        .q(bop_q)
    );

    // ---------------- atan2 pipelines ----------------
    gcdb_vec #(.STAGES(R)) u_vec_theta (
        .clk, .en,
        .y_in(VW'(sa)), .x_in(VW'(sb)),
        .z_out(theta_z)
    );

    gcdb_vec #(.STAGES(R)) u_vec_bear (
        .clk, .en,
        .y_in($signed(bop_q[2*VW-1:VW])), .x_in($signed(bop_q[VW-1:0])),
        .z_out(bear_z)
    );

    // ---------------- stage F: scale products ----------------
    logic [30:0] th;
    logic [34:0] bmag;
    logic [60:0] dist_p_reg;
    logic [63:0] bm_reg;
    logic        bneg_reg;

    always_comb
    begin
        if (theta_z[VW-1])
        begin
            th = '0;
        end
        else if (theta_z > gcdb_pkg::HALF_PI_Q30)
        begin
            th = 31'(gcdb_pkg::HALF_PI_Q30);
        end
        else
        begin
            th = theta_z[30:0];
        end
        bmag = bear_z[VW-1] ? 35'(-bear_z) : 35'(bear_z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_p_reg <= 61'(gcdb_pkg::RADIUS_CM) * 61'(th);
            bm_reg     <= 64'(bmag) * 64'(gcdb_pkg::RAD_TO_CDEG);
            bneg_reg   <= bear_z[VW-1];
        end
    end

    // ---------------- stage G: rounding, wrap, output register ----------------
    logic [61:0]        dsum;
    logic [30:0]        dist_sat;
    logic [63:0]        rsum;
    logic signed [16:0] cdeg;
    logic [30:0]        dist_reg;
    logic [15:0]        bear_reg;

    always_comb
    begin
        dsum = 62'(dist_p_reg) + 62'd268435456;
        if ((dsum >> 29) > 62'(gcdb_pkg::DIST_MAX))
        begin
            dist_sat = gcdb_pkg::DIST_MAX;
        end
        else
        begin
            dist_sat = dsum[59:29];
        end
        rsum = bm_reg + 64'd140737488355328;
        cdeg = bneg_reg ? -$signed({2'b00, rsum[62:48]}) : $signed({2'b00, rsum[62:48]});
        if (cdeg < 0)                    cdeg = cdeg + gcdb_pkg::CDEG_TURN;
        if (cdeg >= gcdb_pkg::CDEG_TURN) cdeg = cdeg - gcdb_pkg::CDEG_TURN;
        if (cdeg < 0)                    cdeg = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= kn_reg[L-2] ? dist_sat : '0;
            bear_reg <= kn_reg[L-2] ? cdeg[15:0] : '0;
        end
    end

    assign res.valid        = vld_reg[L-1];
    assign res.home_known   = kn_reg[L-1];
    assign res.distance_cm  = dist_reg;
    assign res.bearing_cdeg = bear_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPL(a_home_zero, res.valid && !res.home_known,
                 res.distance_cm == '0 && res.bearing_cdeg == '0)
    `ASSERT_IMPL(a_bear_range, res.valid, res.bearing_cdeg < 16'd36000)
    `ASSERT_IMPL(a_dist_range, res.valid, res.distance_cm <= gcdb_pkg::DIST_MAX)
    `ASSERT_IMPL(a_stall_block, res.valid && !res.ready, !pos.ready)

endmodule

// ===== hdl/gcdb_dly.sv =====
// Enable-gated delay line for side data that rides along a pipeline.
// No dependencies.
module gcdb_dly #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] sh_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                sh_reg[i] <= sh_reg[i-1];
            end
        end
    end

    assign q = sh_reg[N-1];
endmodule

// ===== hdl/gcdb_rot.sv =====
// Pipelined rotation-mode CORDIC: sin and cos of a Q30 angle, one stage per step.
// Depends on gcdb_pkg.
module gcdb_rot #(
    parameter int STAGES = 24
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] z_in,
    output logic signed [31:0] c_out,
    output logic signed [31:0] s_out
);
    localparam int CW = gcdb_pkg::CW;

    logic signed [CW-1:0] x_tap [STAGES+1];
    logic signed [CW-1:0] y_tap [STAGES+1];
    logic signed [CW-1:0] z_tap [STAGES+1];
    logic signed [CW-1:0] x_reg [STAGES];
    logic signed [CW-1:0] y_reg [STAGES];
    logic signed [CW-1:0] z_reg [STAGES];

    assign x_tap[0] = gcdb_pkg::CORDIC_X0;
    assign y_tap[0] = '0;
    assign z_tap[0] = CW'(z_in);

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic signed [CW-1:0] x_next, y_next, z_next;
        logic signed [CW-1:0] dx, dy, at;

        always_comb
        begin
            dx = y_tap[g] >>> g;
            dy = x_tap[g] >>> g;
            at = CW'(gcdb_pkg::atan_q30(g));
            if (!z_tap[g][CW-1])
            begin
                x_next = x_tap[g] - dx;
                y_next = y_tap[g] + dy;
                z_next = z_tap[g] - at;
            end
            else
            begin
                x_next = x_tap[g] + dx;
                y_next = y_tap[g] - dy;
                z_next = z_tap[g] + at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g] <= x_next;
                y_reg[g] <= y_next;
                z_reg[g] <= z_next;
            end
        end

        assign x_tap[g+1] = x_reg[g];
        assign y_tap[g+1] = y_reg[g];
        assign z_tap[g+1] = z_reg[g];
    end

    assign c_out = x_tap[STAGES][31:0];
    assign s_out = y_tap[STAGES][31:0];
endmodule

// ===== hdl/gcdb_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
// Depends on gcdb_pkg.
module gcdb_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [60:0] n_in,
    output logic [30:0] root
);
    localparam int NS  = gcdb_pkg::SQRT_STAGES;
    localparam int SQW = gcdb_pkg::SQW;

    logic [SQW-1:0] n_tap [NS+1];
    logic [SQW-1:0] r_tap [NS+1];
    logic [SQW-1:0] n_reg [NS];
    logic [SQW-1:0] r_reg [NS];

    assign n_tap[0] = SQW'(n_in);
    assign r_tap[0] = '0;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (NS - 1 - k));
        logic [SQW-1:0] sum, n_next, r_next;

        always_comb
        begin
            sum = r_tap[k] + BIT;
            if (n_tap[k] >= sum)
            begin
                n_next = n_tap[k] - sum;
                r_next = (r_tap[k] >> 1) + BIT;
            end
            else
            begin
                n_next = n_tap[k];
                r_next = r_tap[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
            end
        end

        assign n_tap[k+1] = n_reg[k];
        assign r_tap[k+1] = r_reg[k];
    end

    assign root = r_tap[NS][30:0];
endmodule

// ===== hdl/gcdb_vec.sv =====
// Pipelined vectoring-mode CORDIC atan2 with quadrant pre-rotation.
// Depends on gcdb_pkg.
module gcdb_vec #(
    parameter int STAGES = 24
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [gcdb_pkg::VW-1:0] y_in,
    input  logic signed [gcdb_pkg::VW-1:0] x_in,
    output logic signed [gcdb_pkg::VW-1:0] z_out
);
    localparam int VW = gcdb_pkg::VW;

    logic signed [VW-1:0] x_tap [STAGES+1];
    logic signed [VW-1:0] y_tap [STAGES+1];
    logic signed [VW-1:0] z_tap [STAGES+1];
    logic signed [VW-1:0] x_reg [STAGES+1];
    logic signed [VW-1:0] y_reg [STAGES+1];
    logic signed [VW-1:0] z_reg [STAGES+1];
    logic                 zf_reg [STAGES+1];
    logic signed [VW-1:0] x0_next, y0_next, z0_next;

    // quadrant fold so x starts non-negative
    always_comb
    begin
        x0_next = x_in;
        y0_next = y_in;
        z0_next = '0;
        if (x_in[VW-1])
        begin
            if (!y_in[VW-1])
            begin
                x0_next = y_in;
                y0_next = -x_in;
                z0_next = gcdb_pkg::HALF_PI_Q30;
            end
            else
            begin
                x0_next = -y_in;
                y0_next = x_in;
                z0_next = -gcdb_pkg::HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= x0_next;
            y_reg[0]  <= y0_next;
            z_reg[0]  <= z0_next;
            zf_reg[0] <= (x_in == '0) && (y_in == '0);
            for (int i = 1; i <= STAGES; i++)
            begin
                zf_reg[i] <= zf_reg[i-1];
            end
        end
    end

    for (genvar g = 0; g <= STAGES; g++)
    begin : g_tap
        assign x_tap[g] = x_reg[g];
        assign y_tap[g] = y_reg[g];
        assign z_tap[g] = z_reg[g];
    end

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic signed [VW-1:0] x_next, y_next, z_next;
        logic signed [VW-1:0] dx, dy, at;

        always_comb
        begin
            dx = y_tap[g] >>> g;
            dy = x_tap[g] >>> g;
            at = gcdb_pkg::atan_q30(g);
            if (!y_tap[g][VW-1])
            begin
                x_next = x_tap[g] + dx;
                y_next = y_tap[g] - dy;
                z_next = z_tap[g] + at;
            end
            else
            begin
                x_next = x_tap[g] - dx;
                y_next = y_tap[g] + dy;
                z_next = z_tap[g] - at;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g+1] <= x_next;
                y_reg[g+1] <= y_next;
                z_reg[g+1] <= z_next;
            end
        end
    end

    assign z_out = zf_reg[STAGES] ? '0 : z_tap[STAGES];
endmodule
